// ===== src/cbwf_pkg.sv =====
package cbwf_pkg;

	// Counter width and banned word length limit.
	localparam int COUNT_BITS = 16;
	localparam int WORD_BYTES = 8;
	localparam int WORDS      = 2;
	localparam int IDX_BITS   = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

	// Register field widths.
	localparam int LIMIT_BITS = 17;
	localparam int TEXT_BITS  = 64;
	localparam int LEN_BITS   = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_CAPS_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_TEXT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_LEN   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_TEXT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_LEN  = 3'd4;

	// Values after reset: "badword1" and "badword2", first character lowest.
	localparam logic [LIMIT_BITS-1:0] RST_CAPS_LIMIT  = 17'd45875;
	localparam logic [TEXT_BITS-1:0]  RST_FIRST_TEXT  = 64'h3164726F77646162;
	localparam logic [TEXT_BITS-1:0]  RST_SECOND_TEXT = 64'h3264726F77646162;
	localparam logic [LEN_BITS-1:0]   RST_WORD_LEN    = 4'd8;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

	typedef struct packed {
		logic [7:0] character;
		logic       has_character;
		logic       last_of_message;
	} msg_item_t;

	typedef struct packed {
		logic flagged;
		logic banned_hit;
		logic caps_over_limit;
	} verdict_t;

	// Control handed to every match cell.
	typedef struct packed {
		logic       shift;
		logic       clear;
		logic [7:0] data;
	} cell_ctl_t;

	// Totals of a finished message, waiting for the ratio test.
	typedef struct packed {
		logic [COUNT_BITS-1:0] byte_count;
		logic [COUNT_BITS-1:0] capital_count;
		logic                  word_seen;
	} msg_totals_t;

	// A word of length n has matched when the prefix flag of length n is set.
	// Length zero matches on any byte; lengths beyond the row are clipped.
	function automatic logic word_hit(input logic [WORD_BYTES-1:0] flags,
			input logic [LEN_BITS-1:0] len);
		logic [LEN_BITS-1:0] n;
		logic [IDX_BITS-1:0] idx;
		logic                hit;
		n = (len > LEN_BITS'(WORD_BYTES)) ? LEN_BITS'(WORD_BYTES) : len;
		idx = IDX_BITS'(n - LEN_BITS'(1));
		if (n == '0) begin
			hit = 1'b1;
		end else begin
			hit = flags[idx];
		end
		return hit;
	endfunction

endpackage

// ===== src/cbwf_cell.sv =====
module cbwf_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cbwf_pkg::cell_ctl_t                    ctl,
	input  logic [cbwf_pkg::WORDS-1:0]             prev_hit,
	input  logic [cbwf_pkg::WORDS-1:0][7:0]        word_char,
	output logic [cbwf_pkg::WORDS-1:0]             hit,
	output logic [cbwf_pkg::WORDS-1:0]             hit_next
);
	import cbwf_pkg::*;

	logic [WORDS-1:0] hit_q;
	logic [WORDS-1:0] char_eq;

	// A prefix one byte longer matches when the shorter one did a byte ago
	// and the new byte equals this cell's character of the word.
	always_comb begin
		for (int w = 0; w < WORDS; w++) begin
			char_eq[w] = (ctl.data == word_char[w]);
		end
		hit_next = ctl.shift ? (prev_hit & char_eq) : hit_q;
	end

	// The flags are dropped at the end of every message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (ctl.clear) begin
			hit_q <= '0;
		end else begin
			hit_q <= hit_next;
		end
	end

	assign hit = hit_q;

endmodule

// ===== src/cbwf_verdict.sv =====
module cbwf_verdict (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 totals_valid,
	input  cbwf_pkg::msg_totals_t                totals,
	input  logic [cbwf_pkg::LIMIT_BITS-1:0]      caps_ratio_limit,
	output logic                                 totals_ready,
	output logic                                 verdict_valid,
	input  logic                                 verdict_stall,
	output cbwf_pkg::verdict_t                   verdict
);
	import cbwf_pkg::*;

	localparam int PROD_BITS = LIMIT_BITS + COUNT_BITS;

	logic                 valid_q;
	verdict_t             verdict_q;
	logic [PROD_BITS-1:0] limit_prod;
	logic [PROD_BITS-1:0] caps_scaled;
	logic                 non_empty;
	logic                 over;
	logic                 banned;

	// Exact ratio test: capitals * 65536 against limit * length.
	always_comb begin
		limit_prod  = PROD_BITS'(caps_ratio_limit) * PROD_BITS'(totals.byte_count);
		caps_scaled = PROD_BITS'({totals.capital_count, 16'h0000});
		non_empty   = (totals.byte_count != '0);
		over        = non_empty && (caps_scaled > limit_prod);
		banned      = non_empty && totals.word_seen;
	end

	// The output register frees itself when its request is taken.
	assign totals_ready = !valid_q || !verdict_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (totals_ready) begin
			valid_q <= totals_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (totals_ready && totals_valid) begin
			verdict_q.flagged         <= banned | over;
			verdict_q.banned_hit      <= banned;
			verdict_q.caps_over_limit <= over;
		end
	end

	assign verdict_valid = valid_q;
	assign verdict       = verdict_q;

endmodule

// ===== src/caps_ratio_banned_word_filter.sv =====
// A verdict follows the last item of its message through a totals register, then
// the output register after the ratio test; backpressure can hold it in either.
// Throughput: one item per cycle; a character enters the row of match cells and
// the counters in the cycle it is accepted, and only backpressure stalls input.
// Reset (arst_n low, asynchronous): counters, match flags and valid bits clear,
// and the registers return to a limit of 45875 and the words "badword1"/"badword2".
module caps_ratio_banned_word_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  msg_valid,
	output logic                                  msg_stall,
	input  cbwf_pkg::msg_item_t                   msg,
	output logic                                  verdict_valid,
	input  logic                                  verdict_stall,
	output cbwf_pkg::verdict_t                    verdict,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cbwf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [cbwf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import cbwf_pkg::*;

	logic [LIMIT_BITS-1:0] caps_limit_q;
	logic [TEXT_BITS-1:0]  first_text_q;
	logic [LEN_BITS-1:0]   first_len_q;
	logic [TEXT_BITS-1:0]  second_text_q;
	logic [LEN_BITS-1:0]   second_len_q;

	logic [COUNT_BITS-1:0] byte_count_q;
	logic [COUNT_BITS-1:0] capital_count_q;
	logic                  word_seen_q;
	logic [COUNT_BITS-1:0] byte_count_next;
	logic [COUNT_BITS-1:0] capital_count_next;
	logic                  word_seen_next;

	logic                  valid_s1;
	msg_totals_t           totals_s1;
	logic                  totals_ready;

	logic                  accept;
	logic                  is_capital;
	cell_ctl_t             cell_ctl;

	logic [WORDS-1:0]      hit_row [WORD_BYTES];
	logic [WORDS-1:0]      hit_next_row [WORD_BYTES];
	logic [WORDS-1:0]      prev_row [WORD_BYTES];
	logic [WORD_BYTES-1:0] first_flags;
	logic [WORD_BYTES-1:0] second_flags;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_limit_q  <= RST_CAPS_LIMIT;
			first_text_q  <= RST_FIRST_TEXT;
			first_len_q   <= RST_WORD_LEN;
			second_text_q <= RST_SECOND_TEXT;
			second_len_q  <= RST_WORD_LEN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPS_LIMIT: begin
					caps_limit_q <= cfg_data[LIMIT_BITS-1:0];
				end
				REG_FIRST_TEXT: begin
					first_text_q <= cfg_data[TEXT_BITS-1:0];
				end
				REG_FIRST_LEN: begin
					first_len_q <= cfg_data[LEN_BITS-1:0];
				end
				REG_SECOND_TEXT: begin
					second_text_q <= cfg_data[TEXT_BITS-1:0];
				end
				REG_SECOND_LEN: begin
					second_len_q <= cfg_data[LEN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input requests wait only while the totals register cannot drain.
	assign msg_stall = valid_s1 && !totals_ready;
	assign accept    = msg_valid && !msg_stall;

	always_comb begin
		cell_ctl.shift = accept && msg.has_character;
		cell_ctl.clear = accept && msg.last_of_message;
		cell_ctl.data  = msg.character;
	end

	// Row of match cells; cell j holds the flags for prefixes of length j+1.
	for (genvar j = 0; j < WORD_BYTES; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign prev_row[j] = '1;
		end else begin : g_link
			assign prev_row[j] = hit_row[j-1];
		end

		cbwf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.prev_hit  (prev_row[j]),
			.word_char ({second_text_q[8*j +: 8], first_text_q[8*j +: 8]}),
			.hit       (hit_row[j]),
			.hit_next  (hit_next_row[j])
		);

		assign first_flags[j]  = hit_next_row[j][0];
		assign second_flags[j] = hit_next_row[j][1];
	end

	// Saturating counters and the banned word flag, as they stand after this item.
	always_comb begin
		is_capital = (msg.character >= CHAR_UPPER_A) && (msg.character <= CHAR_UPPER_Z);
		byte_count_next    = byte_count_q;
		capital_count_next = capital_count_q;
		word_seen_next     = word_seen_q;
		if (cell_ctl.shift) begin
			if (byte_count_q != COUNT_MAX) begin
				byte_count_next = byte_count_q + COUNT_BITS'(1);
			end
			if (is_capital && (capital_count_q != COUNT_MAX)) begin
				capital_count_next = capital_count_q + COUNT_BITS'(1);
			end
			if (word_hit(first_flags, first_len_q) || word_hit(second_flags, second_len_q)) begin
				word_seen_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			capital_count_q <= '0;
			word_seen_q     <= 1'b0;
		end else if (cell_ctl.clear) begin
			byte_count_q    <= '0;
			capital_count_q <= '0;
			word_seen_q     <= 1'b0;
		end else begin
			byte_count_q    <= byte_count_next;
			capital_count_q <= capital_count_next;
			word_seen_q     <= word_seen_next;
		end
	end

	// Totals of a finished message wait here for the ratio test. The register
	// takes a new entry whenever it is empty or drains in this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!msg_stall) begin
			valid_s1 <= cell_ctl.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_ctl.clear) begin
			totals_s1.byte_count    <= byte_count_next;
			totals_s1.capital_count <= capital_count_next;
			totals_s1.word_seen     <= word_seen_next;
		end
	end

	cbwf_verdict u_verdict (
		.clk              (clk),
		.arst_n           (arst_n),
		.totals_valid     (valid_s1),
		.totals           (totals_s1),
		.caps_ratio_limit (caps_limit_q),
		.totals_ready     (totals_ready),
		.verdict_valid    (verdict_valid),
		.verdict_stall    (verdict_stall),
		.verdict          (verdict)
	);

`ifndef SYNTHESIS
	// A message end always lands in the totals register.
	a_end_loads_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && msg.last_of_message) |=> valid_s1)
		else $error("message end did not reach the totals register");

	// The byte counter and the word flag start afresh after a message end.
	a_end_clears_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && msg.last_of_message) |=> (byte_count_q == '0 && !word_seen_q))
		else $error("message state not cleared after message end");

	// Capitals are a subset of the bytes.
	a_caps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		capital_count_q <= byte_count_q)
		else $error("capital count exceeds byte count");

	// The flag is the union of the two rules.
	a_flag_union: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.flagged == (verdict.banned_hit | verdict.caps_over_limit)))
		else $error("flagged disagrees with its rules");

	// Totals never overwritten while waiting.
	a_totals_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !totals_ready) |=> (valid_s1 && $stable(totals_s1)))
		else $error("waiting totals were lost");
`endif

endmodule
